// ----- hw/rtl/tsoa_pkg.sv -----
// ----------------------------------------------------------------------------
// tsoa_pkg: shared definitions for the three-axis oversample averager
// Widths, limits and the lane control bundle used by the lanes and top level.
// ----------------------------------------------------------------------------
package tsoa_pkg;

  localparam int MaxSamples  = 16;
  localparam int CountWidth  = 5;
  localparam int SampleWidth = 16;
  localparam int SumWidth    = 20;
  localparam int DivSteps    = SumWidth;
  localparam int StepWidth   = $clog2(DivSteps);
  localparam int RemWidth    = CountWidth;

  // control from the sequencer to each axis lane
  typedef struct packed {
    logic add;    // accumulate the sample, run continues
    logic load;   // accumulate the sample and hand the sum to the divider
    logic clear;  // drop the partial sum
    logic step;   // one restoring division step
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/tsoa_lane.sv -----
// ----------------------------------------------------------------------------
// tsoa_lane: one axis lane
// Running sum plus a bit-serial restoring divider, truncating toward zero.
// ----------------------------------------------------------------------------
module tsoa_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tsoa_pkg::lane_ctrl_t                  ctrl,
  input  logic signed [tsoa_pkg::SampleWidth-1:0] sample,
  input  logic [tsoa_pkg::CountWidth-1:0]       divisor,
  output logic signed [tsoa_pkg::SampleWidth-1:0] avg
);

  logic signed [tsoa_pkg::SumWidth-1:0] sum;
  logic signed [tsoa_pkg::SumWidth-1:0] sum_inc;
  logic [tsoa_pkg::SumWidth-1:0]        mag;
  logic [tsoa_pkg::SumWidth-1:0]        quo;
  logic [tsoa_pkg::RemWidth-1:0]        rem;
  logic                                 neg;
  logic [tsoa_pkg::RemWidth:0]          shifted;
  logic [tsoa_pkg::RemWidth:0]          trial;
  logic [tsoa_pkg::SampleWidth-1:0]     q_low;

  assign sum_inc = sum + {{(tsoa_pkg::SumWidth-tsoa_pkg::SampleWidth){sample[tsoa_pkg::SampleWidth-1]}},
                          sample};
  assign mag     = sum_inc[tsoa_pkg::SumWidth-1] ? (~sum_inc + 1'b1) : sum_inc;
  assign shifted = {rem, quo[tsoa_pkg::SumWidth-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.clear || ctrl.load) begin
      sum <= '0;
    end else if (ctrl.add) begin
      sum <= sum_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= sum_inc[tsoa_pkg::SumWidth-1];
      quo <= mag;
      rem <= '0;
    end else if (ctrl.step) begin
      // keep the trial difference when it does not go negative
      rem <= trial[tsoa_pkg::RemWidth] ? shifted[tsoa_pkg::RemWidth-1:0]
                                       : trial[tsoa_pkg::RemWidth-1:0];
      quo <= {quo[tsoa_pkg::SumWidth-2:0], ~trial[tsoa_pkg::RemWidth]};
    end
  end

  assign q_low = quo[tsoa_pkg::SampleWidth-1:0];
  assign avg   = neg ? (~q_low + 1'b1) : q_low;

endmodule

// ----- hw/rtl/tsoa_merge.sv -----
// ----------------------------------------------------------------------------
// tsoa_merge: result merge and output register
// Combine the three lane averages and the status into one held result.
// ----------------------------------------------------------------------------
module tsoa_merge (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    load,
  input  logic                                    err,
  input  logic signed [tsoa_pkg::SampleWidth-1:0] avg_x,
  input  logic signed [tsoa_pkg::SampleWidth-1:0] avg_y,
  input  logic signed [tsoa_pkg::SampleWidth-1:0] avg_z,
  output logic                                    can_load,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [3*tsoa_pkg::SampleWidth-1:0]      m_axis_tdata,
  output logic [0:0]                              m_axis_tuser
);

  assign can_load = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // zero the averages on an abandoned run
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= err ? '0 : {avg_z, avg_y, avg_x};
      m_axis_tuser <= err;
    end
  end

endmodule

// ----- hw/rtl/three_axis_oversample_averager.sv -----
// ----------------------------------------------------------------------------
// three_axis_oversample_averager: boxcar decimating averager for X, Y, Z
// Sums sample_count signed 16-bit samples per axis, then emits sum / count.
// ----------------------------------------------------------------------------
// Throughput: a sample that does not close a run is taken every cycle; the
//   sample that closes a run holds off input through accept, 20 steps of the
//   per-lane serial divider and output load, a failed transfer through accept and
//   output load, longer while an earlier result still waits on the output.
// Output: m_axis_tvalid rises after the closing transfer has passed through ST_DIV
//   and then ST_PUSH; after a failed transfer it passes through ST_PUSH only.
// Reset (rst, synchronous): sums and sample count cleared, sample_count = 16,
//   output empty.
module three_axis_oversample_averager (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: sample_count
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsoa_pkg::CountWidth-1:0]     cfg_data,
  // input samples
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high (8 bits each)
  input  logic [3*tsoa_pkg::SampleWidth-1:0]  s_axis_tdata,
  // transfer_failed
  input  logic [0:0]                          s_axis_tuser,
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // avg_x, avg_y, avg_z (16 bits each, signed)
  output logic [3*tsoa_pkg::SampleWidth-1:0]  m_axis_tdata,
  // status
  output logic [0:0]                          m_axis_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                         state;
  logic [tsoa_pkg::CountWidth-1:0]    sample_count;
  logic [tsoa_pkg::CountWidth-1:0]    samples_taken;
  logic [tsoa_pkg::CountWidth-1:0]    taken_inc;
  logic [tsoa_pkg::CountWidth-1:0]    div_n;
  logic [tsoa_pkg::StepWidth-1:0]     step_cnt;
  logic                               err;
  logic                               in_xfer;
  logic                               failed;
  logic                               complete;
  logic                               can_load;
  logic                               push;
  tsoa_pkg::lane_ctrl_t               ctrl;
  logic signed [tsoa_pkg::SampleWidth-1:0] smp_x, smp_y, smp_z;
  logic signed [tsoa_pkg::SampleWidth-1:0] avg_x, avg_y, avg_z;

  // Configuration: always ready, ignore zero and counts above the maximum.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= tsoa_pkg::CountWidth'(tsoa_pkg::MaxSamples);
    end else if (cfg_valid && cfg_ready && cfg_data != '0 &&
                 cfg_data <= tsoa_pkg::CountWidth'(tsoa_pkg::MaxSamples)) begin
      sample_count <= cfg_data;
    end
  end

  // Input side: take samples only while no division or result is pending.
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign failed        = s_axis_tuser[0];
  assign taken_inc     = samples_taken + 1'b1;
  // A count lowered below what is already summed closes the run here too.
  assign complete      = (taken_inc >= sample_count);

  // Join byte pairs: high byte above low byte gives the signed sample.
  assign smp_x = s_axis_tdata[15:0];
  assign smp_y = s_axis_tdata[31:16];
  assign smp_z = s_axis_tdata[47:32];

  assign ctrl.add   = in_xfer & ~failed & ~complete;
  assign ctrl.load  = in_xfer & ~failed & complete;
  assign ctrl.clear = in_xfer & failed;
  assign ctrl.step  = (state == ST_DIV);

  assign push = (state == ST_PUSH) & can_load;

  // Run sequencer: accumulate, divide in DivSteps steps, then push; a failed read skips the division.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      samples_taken <= '0;
      step_cnt      <= '0;
      err           <= 1'b0;
      div_n         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (failed) begin
              samples_taken <= '0;
              err           <= 1'b1;
              state         <= ST_PUSH;
            end else if (complete) begin
              samples_taken <= '0;
              div_n         <= taken_inc;
              step_cnt      <= '0;
              err           <= 1'b0;
              state         <= ST_DIV;
            end else begin
              samples_taken <= taken_inc;
            end
          end
        end
        ST_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == tsoa_pkg::StepWidth'(tsoa_pkg::DivSteps - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // hold until the output register can take the result
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // One lane per axis, all driven by the same control.
  tsoa_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (smp_x),
    .divisor (div_n),
    .avg     (avg_x)
  );

  tsoa_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (smp_y),
    .divisor (div_n),
    .avg     (avg_y)
  );

  tsoa_lane u_lane_z (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (smp_z),
    .divisor (div_n),
    .avg     (avg_z)
  );

  // Merge lane results into the output register.
  tsoa_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (push),
    .err           (err),
    .avg_x         (avg_x),
    .avg_y         (avg_y),
    .avg_z         (avg_z),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- test/tb_three_axis_oversample_averager.sv -----
// ----------------------------------------------------------------------------
// tb_three_axis_oversample_averager: self-checking bench for the averager
// Walks a directed table of samples and sample_count writes, then random
// phases of samples under random stalls on both streams. Every accepted
// sample runs through a local boxcar model; each result transfer is checked
// field by field against the oldest expected average.
// ----------------------------------------------------------------------------
module tb_three_axis_oversample_averager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleWidth = tsoa_pkg::SampleWidth;
  localparam int CountWidth  = tsoa_pkg::CountWidth;
  localparam int MaxSamples  = tsoa_pkg::MaxSamples;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 30;    // settle margin after a run closes
  localparam int RandomItems  = 1400;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusFailed = 1'b1;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    logic signed [SampleWidth-1:0] x;
    logic signed [SampleWidth-1:0] y;
    logic signed [SampleWidth-1:0] z;
    logic                          status;
  } axis_avg_t;

  typedef struct {
    row_kind_t                 kind;
    logic [3*SampleWidth-1:0]  data;
    logic                      failed;
    logic [CountWidth-1:0]     count;
    bit                        typed;   // use the typed-in average below
    axis_avg_t                 want;
  } stim_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CountWidth-1:0]       cfg_data = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [3*SampleWidth-1:0]    s_axis_tdata = '0;  // x_low, x_high, y_low, y_high, z_low, z_high
  logic [0:0]                  s_axis_tuser = '0;  // transfer_failed
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [3*SampleWidth-1:0]    m_axis_tdata;       // avg_x, avg_y, avg_z
  logic [0:0]                  m_axis_tuser;       // status

  three_axis_oversample_averager u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Local copy of the averager: running sums, samples in the run, run length.
  int                    acc_x, acc_y, acc_z;
  int                    acc_n;
  logic [CountWidth-1:0] run_len;

  axis_avg_t  pending_avgs[$];
  stim_row_t  directed_rows[$];
  int         err_count   = 0;
  int         cycle_count = 0;
  bit         no_gaps     = 1'b0;  // suppress idling on both streams

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random backpressure on the result stream, none during a no-gap stretch.
  always @(posedge clk) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 13);
  end

  // Watchdog: fail the test once the overall cycle limit is exceeded.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d averages still expected", $realtime,
               pending_avgs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every result transfer against the oldest expected average.
  always @(posedge clk) begin
    axis_avg_t want;
    axis_avg_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x      = m_axis_tdata[SampleWidth-1:0];
      got.y      = m_axis_tdata[2*SampleWidth-1:SampleWidth];
      got.z      = m_axis_tdata[3*SampleWidth-1:2*SampleWidth];
      got.status = m_axis_tuser[0];
      if (pending_avgs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0b", $realtime,
                 got.x, got.y, got.z, got.status);
      end else begin
        want = pending_avgs.pop_front();
        if (got.x !== want.x) begin
          err_count++;
          $display("%0t: avg_x expected %0d got %0d", $realtime, want.x, got.x);
        end
        if (got.y !== want.y) begin
          err_count++;
          $display("%0t: avg_y expected %0d got %0d", $realtime, want.y, got.y);
        end
        if (got.z !== want.z) begin
          err_count++;
          $display("%0t: avg_z expected %0d got %0d", $realtime, want.z, got.z);
        end
        if (got.status !== want.status) begin
          err_count++;
          $display("%0t: status expected %0b got %0b", $realtime, want.status,
                   got.status);
        end
      end
    end
  end

  function automatic int sext16(logic [SampleWidth-1:0] raw);
    return int'(signed'(raw));
  endfunction

  // Accumulate one sample; return 1 and the average when the run closes.
  function automatic bit accumulate_sample(logic [3*SampleWidth-1:0] data, logic failed,
                                           output axis_avg_t avg);
    avg = '{x: '0, y: '0, z: '0, status: StatusOk};
    if (failed) begin
      // drop the partial run and report the failed read
      acc_x = 0; acc_y = 0; acc_z = 0; acc_n = 0;
      avg.status = StatusFailed;
      return 1'b1;
    end
    acc_x += sext16(data[SampleWidth-1:0]);
    acc_y += sext16(data[2*SampleWidth-1:SampleWidth]);
    acc_z += sext16(data[3*SampleWidth-1:2*SampleWidth]);
    acc_n++;
    if (acc_n < int'(run_len))
      return 1'b0;
    // integer division truncates toward zero; the count may exceed run_len
    // when the length was lowered mid-run
    avg.x = SampleWidth'(acc_x / acc_n);
    avg.y = SampleWidth'(acc_y / acc_n);
    avg.z = SampleWidth'(acc_z / acc_n);
    acc_x = 0; acc_y = 0; acc_z = 0; acc_n = 0;
    return 1'b1;
  endfunction

  function automatic logic [3*SampleWidth-1:0] pack_xyz(logic [15:0] x, logic [15:0] y,
                                                       logic [15:0] z);
    return {z, y, x};
  endfunction

  task automatic add_row(row_kind_t kind, logic [3*SampleWidth-1:0] data, logic failed,
                         logic [CountWidth-1:0] count, bit typed, int wx, int wy, int wz,
                         logic st);
    stim_row_t r;
    r.kind   = kind;
    r.data   = data;
    r.failed = failed;
    r.count  = count;
    r.typed  = typed;
    r.want   = '{x: SampleWidth'(wx), y: SampleWidth'(wy), z: SampleWidth'(wz), status: st};
    directed_rows.push_back(r);
  endtask

  // Present one sample, hold it until the transfer, then queue any average it closes.
  task automatic send_sample(logic [3*SampleWidth-1:0] data, logic failed, bit typed,
                             axis_avg_t typed_avg);
    axis_avg_t avg;
    if (!no_gaps && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= failed;
    do @(posedge clk); while (!s_axis_tready);
    if (accumulate_sample(data, failed, avg))
      pending_avgs.push_back(typed ? typed_avg : avg);
  endtask

  // Drain all results, let any open run settle, then write sample_count.
  task automatic write_count(logic [CountWidth-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // out-of-range lengths leave the register as it was
    if (value >= 1 && value <= MaxSamples)
      run_len = value;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    axis_avg_t none;
    int        sent;
    int        phase;
    int        phase_items;

    none    = '{x: '0, y: '0, z: '0, status: StatusOk};
    run_len = MaxSamples;
    acc_x = 0; acc_y = 0; acc_z = 0; acc_n = 0;

    // Extremes with a run length of one, so each sample is its own average.
    add_row(ROW_CFG,    '0, 1'b0, 5'd1, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h7FFF, 16'h8000, 16'h0000), 1'b0, '0, 1,
            32767, -32768, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'hFFFF, 16'h0001, 16'h8001), 1'b0, '0, 1,
            -1, 1, -32767, StatusOk);
    add_row(ROW_SAMPLE, {48{1'b1}}, 1'b1, '0, 1, 0, 0, 0, StatusFailed);
    // Out-of-range lengths are ignored: the run length stays one.
    add_row(ROW_CFG,    '0, 1'b0, 5'd0, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h1234, 16'hEDCB, 16'h00FF), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_CFG,    '0, 1'b0, 5'd17, 0, 0, 0, 0, StatusOk);
    add_row(ROW_CFG,    '0, 1'b0, 5'd31, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, '0, 1'b0, '0, 1, 0, 0, 0, StatusOk);
    // Three-sample runs: full negative scale, then truncation toward zero.
    add_row(ROW_CFG,    '0, 1'b0, 5'd3, 0, 0, 0, 0, StatusOk);
    for (int i = 0; i < 3; i++)
      add_row(ROW_SAMPLE, pack_xyz(16'h8000, 16'h8000, 16'h8000), 1'b0, '0, i == 2,
              -32768, -32768, -32768, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'hFFFF, 16'h0001, 16'h7FFF), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'hFFFF, 16'h0001, 16'h7FFF), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h0000, 16'h0000, 16'h7FFF), 1'b0, '0, 1,
            0, 0, 32767, StatusOk);
    // Lower the length below the samples already summed: the next sample
    // closes the run and divides by four.
    add_row(ROW_CFG,    '0, 1'b0, 5'd4, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h0100, 16'hF000, 16'h0007), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h7FFF, 16'h8000, 16'hFFF9), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h0003, 16'h1234, 16'h4000), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_CFG,    '0, 1'b0, 5'd2, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'hC000, 16'h0055, 16'h8001), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    // A failed read in the middle of a run abandons it.
    add_row(ROW_CFG,    '0, 1'b0, 5'd3, 0, 0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, pack_xyz(16'h2222, 16'h3333, 16'h4444), 1'b0, '0, 0,
            0, 0, 0, StatusOk);
    add_row(ROW_SAMPLE, '0, 1'b1, '0, 1, 0, 0, 0, StatusFailed);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_count(directed_rows[i].count);
      else
        send_sample(directed_rows[i].data, directed_rows[i].failed, directed_rows[i].typed,
                    directed_rows[i].want);
    end

    // Random phases: each starts from an idle block with a new run length;
    // runs are left open at phase ends so later writes can shorten them.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (phase % 4 == 3)
        write_count($urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31)));
      case (phase)
        0:       write_count(5'd16);
        1:       write_count(5'd1);
        default: write_count(5'($urandom_range(1, MaxSamples)));
      endcase
      no_gaps     = (phase == 2);
      phase_items = $urandom_range(40, 160);
      for (int k = 0; k < phase_items && sent < RandomItems; k++) begin
        send_sample(pack_xyz(pick_axis(), pick_axis(), pick_axis()),
                    $urandom_range(99) < 3, 1'b0, none);
        sent++;
      end
      no_gaps = 1'b0;
      phase++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- three_axis_oversample_averager.f -----
hw/rtl/tsoa_pkg.sv
hw/rtl/tsoa_lane.sv
hw/rtl/tsoa_merge.sv
hw/rtl/three_axis_oversample_averager.sv
test/tb_three_axis_oversample_averager.sv
